// File: rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg
// Shared constants and types for the space-to-tab compressor.
// ----------------------------------------------------------------------------
package stc_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned WIDTH_W    = 6;
	localparam int unsigned PHASE_W    = 5;
	localparam int unsigned PEND_W     = 6;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 6;

	localparam logic [BYTE_W-1:0] CHAR_TAB = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_NL  = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_SP  = 8'h20;

	localparam logic [WIDTH_W-1:0] TAB_WIDTH_RESET = 6'd8;
	localparam logic [WIDTH_W-1:0] TAB_WIDTH_MAX   = 6'd32;
	localparam logic [PEND_W-1:0]  PEND_MAX        = 6'd33;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TAB_WIDTH = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_ALL_MODE  = 1'b1;

	// Which byte to drop into the output register this cycle
	typedef enum logic [1:0] {
		LD_NONE,
		LD_TAB,
		LD_SPACE,
		LD_CHAR
	} ld_sel_t;

	typedef struct packed {
		logic    accept;
		ld_sel_t ld;
		logic    last;
	} stc_cmd_t;

	typedef struct packed {
		logic plan_tab;    // accepted byte yields a tab
		logic plan_space;  // accepted byte yields flushed spaces
		logic plan_char;   // accepted byte is passed on
		logic space_left;  // space count not yet exhausted
		logic space_one;   // exactly one space left
		logic char_left;   // passed byte still to send
		logic out_free;    // output register can take a byte
	} stc_sts_t;

endpackage

// File: rtl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl
// Sequencer: accepts a byte, then steps through tab, spaces and the byte.
// ----------------------------------------------------------------------------
module stc_ctrl import stc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  stc_sts_t sts,
	output stc_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_TAB,
		S_SPACE,
		S_CHAR
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   stall_q;

	always_comb begin
		cmd       = '{accept: 1'b0, ld: LD_NONE, last: 1'b0};
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.plan_tab)
						state_nxt = S_TAB;
					else if (sts.plan_space)
						state_nxt = S_SPACE;
					else if (sts.plan_char)
						state_nxt = S_CHAR;
				end
			end
			S_TAB: begin
				if (sts.out_free) begin
					cmd.ld   = LD_TAB;
					cmd.last = !sts.space_left && !sts.char_left;
					if (sts.space_left)
						state_nxt = S_SPACE;
					else if (sts.char_left)
						state_nxt = S_CHAR;
					else
						state_nxt = S_IDLE;
				end
			end
			S_SPACE: begin
				if (sts.out_free) begin
					cmd.ld   = LD_SPACE;
					cmd.last = sts.space_one && !sts.char_left;
					if (sts.space_one)
						state_nxt = sts.char_left ? S_CHAR : S_IDLE;
				end
			end
			S_CHAR: begin
				if (sts.out_free) begin
					cmd.ld    = LD_CHAR;
					cmd.last  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// Hold off input whenever a byte plan is still being sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stall_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			stall_q <= (state_nxt != S_IDLE);
		end
	end

	assign in_stall = stall_q;

endmodule

// File: rtl/stc_dp.sv
// ----------------------------------------------------------------------------
// stc_dp
// Datapath: configuration, line state, byte plan and output register.
// ----------------------------------------------------------------------------
module stc_dp import stc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [BYTE_W-1:0]     in_byte,
	input  stc_cmd_t              cmd,
	output stc_sts_t              sts,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  last
);

	// Configuration
	logic [WIDTH_W-1:0] tab_width_q;
	logic               all_mode_q;

	// Line state
	logic [PEND_W-1:0]  pend_q;
	logic               line_start_q;
	logic [PHASE_W-1:0] phase_q;
	logic               prev_sp_q;

	// Byte plan of the accepted item
	logic [PEND_W-1:0]  cnt_q;
	logic               chr_q;
	logic [BYTE_W-1:0]  byte_q;

	// Output register
	logic               out_valid_q;
	logic [BYTE_W-1:0]  out_byte_q;
	logic               out_last_q;

	logic [WIDTH_W-1:0] tw;
	logic               is_sp;
	logic               is_nl;
	logic [PEND_W-1:0]  pend_a;
	logic [PEND_W:0]    pend_inc;
	logic [WIDTH_W-1:0] phase_inc;
	logic [PEND_W-1:0]  n_pend;
	logic               n_line_start;
	logic [PHASE_W-1:0] n_phase;
	logic               n_prev_sp;
	logic               p_tab;
	logic [PEND_W-1:0]  p_cnt;
	logic               p_chr;
	logic               out_free;

	always_comb begin
		if (tab_width_q == '0)
			tw = WIDTH_W'(1);
		else if (tab_width_q > TAB_WIDTH_MAX)
			tw = TAB_WIDTH_MAX;
		else
			tw = tab_width_q;
	end

	assign is_sp = (in_byte == CHAR_SP);
	assign is_nl = (in_byte == CHAR_NL);

	always_comb begin
		n_pend       = pend_q;
		n_line_start = line_start_q;
		n_phase      = phase_q;
		n_prev_sp    = prev_sp_q;
		p_tab        = 1'b0;
		p_cnt        = '0;
		p_chr        = 1'b0;
		pend_a       = pend_q;
		pend_inc     = {1'b0, pend_q} + (PEND_W+1)'(1);
		phase_inc    = {1'b0, phase_q} + WIDTH_W'(1);
		if (!all_mode_q) begin
			if (line_start_q && is_sp) begin
				if (pend_inc >= {1'b0, tw}) begin
					p_tab  = 1'b1;
					n_pend = '0;
				end else begin
					n_pend = pend_inc[PEND_W-1:0];
				end
			end else begin
				n_line_start = is_nl;
				p_cnt        = (pend_q > PEND_MAX) ? PEND_MAX : pend_q;
				n_pend       = '0;
				p_chr        = 1'b1;
			end
		end else begin
			// Tab stop reached after a run of more than one space
			if (phase_q == '0 && prev_sp_q && pend_q > PEND_W'(1)) begin
				p_tab  = 1'b1;
				pend_a = '0;
			end
			pend_inc = {1'b0, pend_a} + (PEND_W+1)'(1);
			n_phase  = (phase_inc >= tw) ? '0 : phase_inc[PHASE_W-1:0];
			if (is_sp) begin
				n_prev_sp = 1'b1;
				if (prev_sp_q)
					n_pend = (pend_a < PEND_MAX) ? pend_inc[PEND_W-1:0] : pend_a;
				else
					n_pend = PEND_W'(1);
			end else begin
				p_chr     = 1'b1;
				n_prev_sp = 1'b0;
				if (prev_sp_q) begin
					p_cnt  = (pend_a > PEND_MAX) ? PEND_MAX : pend_a;
					n_pend = '0;
				end else begin
					n_pend = pend_a;
				end
				if (is_nl) begin
					n_pend    = '0;
					n_phase   = '0;
					n_prev_sp = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tab_width_q <= TAB_WIDTH_RESET;
			all_mode_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IDX_TAB_WIDTH: tab_width_q <= cfg_data;
				CFG_IDX_ALL_MODE:  all_mode_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q       <= '0;
			line_start_q <= 1'b1;
			phase_q      <= '0;
			prev_sp_q    <= 1'b1;
		end else if (cmd.accept) begin
			pend_q       <= n_pend;
			line_start_q <= n_line_start;
			phase_q      <= n_phase;
			prev_sp_q    <= n_prev_sp;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cnt_q  <= p_cnt;
			chr_q  <= p_chr;
			byte_q <= in_byte;
		end else if (cmd.ld == LD_SPACE) begin
			cnt_q <= cnt_q - PEND_W'(1);
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.ld != LD_NONE)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.ld != LD_NONE) begin
			out_last_q <= cmd.last;
			case (cmd.ld)
				LD_TAB:   out_byte_q <= CHAR_TAB;
				LD_SPACE: out_byte_q <= CHAR_SP;
				default:  out_byte_q <= byte_q;
			endcase
		end
	end

	always_comb begin
		sts.plan_tab   = p_tab;
		sts.plan_space = (p_cnt != '0);
		sts.plan_char  = p_chr;
		sts.space_left = (cnt_q != '0);
		sts.space_one  = (cnt_q == PEND_W'(1));
		sts.char_left  = chr_q;
		sts.out_free   = out_free;
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = out_last_q;

endmodule

// File: rtl/space_to_tab_compressor_unit.sv
// ----------------------------------------------------------------------------
// space_to_tab_compressor_unit
// Turns runs of spaces in a byte stream into tabs at a programmable width.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  input    | in        | in_valid / in_stall | in_byte
//  output   | out       | out_valid/out_stall | out_byte, last
//  config   | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  An input transaction is taken while the sequencer is idle; it then
//  produces n output bytes (0 to 34), one per cycle into the single
//  output register unless out_stall holds it. The last byte of an item
//  is taken in while it waits in the output register, and the next input
//  transaction may already land.
//  Reset clears the line state and sets tab_width to 8, leading mode.
//  Output stall holds the output register and the sequencer's send states.
//
module space_to_tab_compressor_unit import stc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// input byte stream
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [BYTE_W-1:0]     in_byte,
	// output byte stream
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [BYTE_W-1:0]     out_byte,
	output logic                  last,
	// configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	stc_cmd_t cmd;
	stc_sts_t sts;
	logic     cfg_we;

	// Register writes are always taken; the user must send them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequencer: accept a byte, then send tab, spaces and the byte in order
	stc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath: line state update, byte plan and the output register
	stc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_byte   (in_byte),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule
